[rtl/hkl_pkg.sv]
`default_nettype none

package hkl_pkg;

   // Table geometry and field widths.
   localparam int TABLE_DEPTH = 512;
   localparam int SLOT_W      = 9;
   localparam int CNT_W       = 10;
   localparam int KEY_W       = 48;
   localparam int NIB_W       = 4;
   localparam logic [NIB_W-1:0] KEY_NIBBLES = 4'd12;

   // Request command codes.
   localparam logic [1:0] CMD_TEXT   = 2'd0;
   localparam logic [1:0] CMD_INSERT = 2'd1;
   localparam logic [1:0] CMD_READ   = 2'd2;

   // Result status codes.
   localparam logic [2:0] ST_ADDED = 3'd0;
   localparam logic [2:0] ST_DUP   = 3'd1;
   localparam logic [2:0] ST_FULL  = 3'd2;
   localparam logic [2:0] ST_BAD   = 3'd3;
   localparam logic [2:0] ST_READ  = 3'd4;
   localparam logic [2:0] ST_RANGE = 3'd5;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       parse;
      logic       load_pend;
      logic       rd_entry;
      logic       scan_start;
      logic       scan_issue;
      logic       tbl_write;
      logic       out_load;
      logic [2:0] out_status;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;
      logic line_ok;
      logic idx_ok;
      logic full;
      logic empty;
      logic issue_more;
      logic match;
      logic last_cmp;
   } dp_stat_type;

endpackage

`default_nettype wire

[rtl/hex_key_line_dedup_loader_top.sv]
`default_nettype none

// Hex key line loader with a deduplicating table of up to 512 48-bit keys.
// Text beats (command 0) are taken in idle and give a result only on the beat
// that ends a line; a malformed or short line reports at once. A key from a
// line or from a direct insert (command 1) reports from the insert state when
// the table is empty or full, and otherwise after a scan where the duplicate
// check reads the stored keys one per cycle through the table's single read
// port. A read (command 2) goes through a read state, or reports from idle
// when the index is beyond the count. One item is worked on at a time; a
// finished result sits in an output register, and the next beat is accepted
// while it waits as long as it is taken in the same cycle. The table needs no
// clearing after reset: only entries below the key count are ever read.
module hex_key_line_dedup_loader_top import hkl_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [1:0]        req_command,
   input  wire logic [7:0]        req_ch,
   input  wire logic              req_last_in_line,
   input  wire logic [KEY_W-1:0]  req_key,
   input  wire logic [SLOT_W-1:0] req_index,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [2:0]             rsp_status,
   output logic [KEY_W-1:0]       rsp_key_value,
   output logic [CNT_W-1:0]       rsp_entry_count,
   output logic [SLOT_W-1:0]      rsp_entry_slot
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // Sequencer.
   hkl_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_last_in_line (req_last_in_line),
      .stat             (stat),
      .cmd              (cmd)
   );

   // Parser, key table and result register.
   hkl_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .req_last_in_line (req_last_in_line),
      .req_command      (req_command),
      .req_key          (req_key),
      .req_index        (req_index),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_key_value    (rsp_key_value),
      .rsp_entry_count  (rsp_entry_count),
      .rsp_entry_slot   (rsp_entry_slot)
   );

endmodule

`default_nettype wire

[rtl/hkl_ctrl.sv]
`default_nettype none

module hkl_ctrl import hkl_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_command,
   input  wire logic        req_last_in_line,
   input  wire dp_stat_type stat,
   output dp_cmd_type       cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_INS  = 2'd1;
   localparam logic [1:0] S_SCAN = 2'd2;
   localparam logic [1:0] S_READ = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       accept;

   // Beats are taken only in idle and only when the result register can take a result.
   assign req_ready = (state_ff == S_IDLE) && stat.out_free;
   assign accept    = req_valid && req_ready;

   // Next state and datapath commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_command)
                  CMD_TEXT: begin
                     cmd.parse = 1'b1;
                     if (req_last_in_line) begin
                        if (stat.line_ok) begin
                           cmd.load_pend = 1'b1;
                           state_in      = S_INS;
                        end else begin
                           cmd.out_load   = 1'b1;
                           cmd.out_status = ST_BAD;
                        end
                     end
                  end
                  CMD_INSERT: begin
                     cmd.load_pend = 1'b1;
                     state_in      = S_INS;
                  end
                  CMD_READ: begin
                     if (stat.idx_ok) begin
                        cmd.rd_entry = 1'b1;
                        state_in     = S_READ;
                     end else begin
                        cmd.out_load   = 1'b1;
                        cmd.out_status = ST_RANGE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_INS: begin
            if (stat.full) begin
               cmd.out_load   = 1'b1;
               cmd.out_status = ST_FULL;
               state_in       = S_IDLE;
            end else if (stat.empty) begin
               cmd.tbl_write  = 1'b1;
               cmd.out_load   = 1'b1;
               cmd.out_status = ST_ADDED;
               state_in       = S_IDLE;
            end else begin
               cmd.scan_start = 1'b1;
               state_in       = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan_issue = stat.issue_more;
            if (stat.match) begin
               cmd.out_load   = 1'b1;
               cmd.out_status = ST_DUP;
               state_in       = S_IDLE;
            end else if (stat.last_cmp) begin
               cmd.tbl_write  = 1'b1;
               cmd.out_load   = 1'b1;
               cmd.out_status = ST_ADDED;
               state_in       = S_IDLE;
            end
         end
         S_READ: begin
            cmd.out_load   = 1'b1;
            cmd.out_status = ST_READ;
            state_in       = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[rtl/hkl_dp.sv]
`default_nettype none

module hkl_dp import hkl_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [7:0]        req_ch,
   input  wire logic              req_last_in_line,
   input  wire logic [1:0]        req_command,
   input  wire logic [KEY_W-1:0]  req_key,
   input  wire logic [SLOT_W-1:0] req_index,
   input  wire dp_cmd_type        cmd,
   output dp_stat_type            stat,
   input  wire logic              rsp_ready,
   output logic                   rsp_valid,
   output logic [2:0]             rsp_status,
   output logic [KEY_W-1:0]       rsp_key_value,
   output logic [CNT_W-1:0]       rsp_entry_count,
   output logic [SLOT_W-1:0]      rsp_entry_slot
);

   // Hex digit decode: bit 4 set when the character is a hex digit.
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] v;
      v = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         v = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         v = {1'b1, 4'(c - 8'h37)};
      end
      return v;
   endfunction

   localparam logic [7:0] CH_HASH = 8'h23;
   localparam logic [7:0] CH_SEMI = 8'h3B;
   localparam logic [7:0] CH_NUL  = 8'h00;
   localparam logic [7:0] CH_TAB  = 8'h09;
   localparam logic [7:0] CH_CR   = 8'h0D;
   localparam logic [7:0] CH_SPC  = 8'h20;

   // Line parser state.
   logic [NIB_W-1:0]  nib_ff, nib_in;
   logic [KEY_W-1:0]  shift_ff, shift_in;
   logic              stop_ff, stop_in;
   logic              bad_ff, bad_in;
   logic [4:0]        hv;

   // Table, count, pending key and scan state.
   logic [KEY_W-1:0]  key_mem [TABLE_DEPTH];
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [KEY_W-1:0]  pend_ff;
   logic [SLOT_W-1:0] issue_ff;
   logic [SLOT_W-1:0] rd_addr;
   logic              rd_en;
   logic [KEY_W-1:0]  rd_data_ff;
   logic [SLOT_W-1:0] rd_slot_ff;
   logic              rd_vld_ff;

   // Result register.
   logic              out_valid_ff, out_valid_in;
   logic [2:0]        out_status_ff;
   logic [KEY_W-1:0]  out_key_ff, out_key_in;
   logic [CNT_W-1:0]  out_count_ff;
   logic [SLOT_W-1:0] out_slot_ff, out_slot_in;

   // Parse one character into the line state.
   always_comb begin
      hv       = hex_value(req_ch);
      nib_in   = nib_ff;
      shift_in = shift_ff;
      stop_in  = stop_ff;
      bad_in   = bad_ff;
      if (!stop_ff && nib_ff < KEY_NIBBLES) begin
         if (req_ch == CH_HASH || req_ch == CH_SEMI || req_ch == CH_NUL) begin
            stop_in = 1'b1;
         end else if ((req_ch >= CH_TAB && req_ch <= CH_CR) || req_ch == CH_SPC) begin
            stop_in = stop_ff;
         end else if (hv[4]) begin
            shift_in = {shift_ff[KEY_W-5:0], hv[3:0]};
            nib_in   = nib_ff + 4'd1;
         end else begin
            bad_in  = 1'b1;
            stop_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nib_ff   <= '0;
         shift_ff <= '0;
         stop_ff  <= 1'b0;
         bad_ff   <= 1'b0;
      end else if (cmd.parse) begin
         if (req_last_in_line) begin
            nib_ff   <= '0;
            shift_ff <= '0;
            stop_ff  <= 1'b0;
            bad_ff   <= 1'b0;
         end else begin
            nib_ff   <= nib_in;
            shift_ff <= shift_in;
            stop_ff  <= stop_in;
            bad_ff   <= bad_in;
         end
      end
   end

   // Pending key: the finished line or the direct key.
   always_ff @(posedge clock) begin
      if (cmd.load_pend) begin
         pend_ff <= (req_command == CMD_TEXT) ? shift_in : req_key;
      end
   end

   // Key count.
   assign count_in = cmd.tbl_write ? count_ff + 10'd1 : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Scan address counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff <= '0;
      end else if (cmd.scan_start) begin
         issue_ff <= '0;
      end else if (cmd.scan_issue) begin
         issue_ff <= issue_ff + 9'd1;
      end
   end

   // Key table: one write port, one registered read port.
   assign rd_en   = cmd.scan_issue || cmd.rd_entry;
   assign rd_addr = cmd.scan_issue ? issue_ff : req_index;

   always_ff @(posedge clock) begin
      if (cmd.tbl_write) begin
         key_mem[count_ff[SLOT_W-1:0]] <= pend_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= key_mem[rd_addr];
         rd_slot_ff <= rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= rd_en;
      end
   end

   // Status back to the controller.
   always_comb begin
      stat.out_free   = !out_valid_ff || rsp_ready;
      stat.line_ok    = !bad_in && (nib_in == KEY_NIBBLES);
      stat.idx_ok     = ({1'b0, req_index} < count_ff) &&
                        ({1'b0, req_index} < CNT_W'(TABLE_DEPTH));
      stat.full       = count_ff >= CNT_W'(TABLE_DEPTH);
      stat.empty      = count_ff == '0;
      stat.issue_more = {1'b0, issue_ff} < count_ff;
      stat.match      = rd_vld_ff && (rd_data_ff == pend_ff);
      stat.last_cmp   = rd_vld_ff && ({1'b0, rd_slot_ff} == count_ff - 10'd1);
   end

   // Result fields by status.
   always_comb begin
      case (cmd.out_status)
         ST_ADDED, ST_DUP, ST_FULL: out_key_in = pend_ff;
         ST_READ:                   out_key_in = rd_data_ff;
         default:                   out_key_in = '0;
      endcase
      case (cmd.out_status)
         ST_ADDED:        out_slot_in = count_ff[SLOT_W-1:0];
         ST_DUP, ST_READ: out_slot_in = rd_slot_ff;
         ST_RANGE:        out_slot_in = req_index;
         default:         out_slot_in = '0;
      endcase
   end

   // Result register: holds a beat until it is taken.
   assign out_valid_in = cmd.out_load ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_status_ff <= cmd.out_status;
         out_key_ff    <= out_key_in;
         out_count_ff  <= count_in;
         out_slot_ff   <= out_slot_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_key_value   = out_key_ff;
   assign rsp_entry_count = out_count_ff;
   assign rsp_entry_slot  = out_slot_ff;

endmodule

`default_nettype wire

[rtl/hkl_check.sv]
`default_nettype none

module hkl_check import hkl_pkg::*; (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic [1:0]        req_command,
   input wire logic [7:0]        req_ch,
   input wire logic              req_last_in_line,
   input wire logic [KEY_W-1:0]  req_key,
   input wire logic [SLOT_W-1:0] req_index,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [2:0]        rsp_status,
   input wire logic [KEY_W-1:0]  rsp_key_value,
   input wire logic [CNT_W-1:0]  rsp_entry_count,
   input wire logic [SLOT_W-1:0] rsp_entry_slot
);

   // A stalled result beat holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_key_value) && $stable(rsp_entry_count) && $stable(rsp_entry_slot))
      else $error("result beat changed while stalled");

   // The key count never passes the table size.
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_entry_count <= CNT_W'(TABLE_DEPTH))
      else $error("entry count beyond table size");

   // An added key lands in the slot just below the new count.
   a_added_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_ADDED |->
      rsp_entry_count != '0 && rsp_entry_slot == SLOT_W'(rsp_entry_count - 10'd1))
      else $error("added key slot does not match count");

   // A malformed line reports no key and slot zero.
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_BAD |-> rsp_key_value == '0 && rsp_entry_slot == '0)
      else $error("malformed line result carries data");

   // A duplicate or a read points below the count.
   a_slot_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_DUP || rsp_status == ST_READ) |->
      {1'b0, rsp_entry_slot} < rsp_entry_count)
      else $error("slot of a held key beyond count");

endmodule

bind hex_key_line_dedup_loader_top hkl_check u_check (.*);

`default_nettype wire

[bench/hkl_result_checker.sv]
module hkl_result_checker import hkl_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_ready,
   input  wire logic [1:0]        req_command,
   input  wire logic [7:0]        req_ch,
   input  wire logic              req_last_in_line,
   input  wire logic [KEY_W-1:0]  req_key,
   input  wire logic [SLOT_W-1:0] req_index,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_ready,
   input  wire logic [2:0]        rsp_status,
   input  wire logic [KEY_W-1:0]  rsp_key_value,
   input  wire logic [CNT_W-1:0]  rsp_entry_count,
   input  wire logic [SLOT_W-1:0] rsp_entry_slot,
   output int                     mismatch_count,
   output int                     awaited_count
);

   // Characters with a meaning of their own to the line parser.
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_SEMI  = 8'h3B;

   typedef struct packed {
      logic [2:0]        status;
      logic [KEY_W-1:0]  key_value;
      logic [CNT_W-1:0]  entry_count;
      logic [SLOT_W-1:0] entry_slot;
   } loader_result_type;

   // Shadow copy of the key store and of the line parser.
   logic [KEY_W-1:0]  held_keys [TABLE_DEPTH];
   int                held_total;
   logic [NIB_W-1:0]  line_nibbles;
   logic [KEY_W-1:0]  line_key;
   logic              line_stopped;
   logic              line_bad;
   loader_result_type awaited_results [$];
   int                fails;

   // Prints one line per mismatch and counts it.
   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      fails++;
   endtask

   // Value of a hex digit in either case; bit 4 is set for a digit.
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      if (c >= "0" && c <= "9") begin
         return {1'b1, 4'(c - "0")};
      end else if (c >= "a" && c <= "f") begin
         return {1'b1, 4'(c - "a" + 8'd10)};
      end else if (c >= "A" && c <= "F") begin
         return {1'b1, 4'(c - "A" + 8'd10)};
      end
      return 5'd0;
   endfunction

   // One character of the current line. Once twelve nibbles are held or
   // the line has been stopped, the rest of the line is ignored.
   task automatic parse_char(input logic [7:0] c);
      logic [4:0] digit;
      digit = hex_value(c);
      if (!line_stopped && line_nibbles < KEY_NIBBLES) begin
         if (c == CH_HASH || c == CH_SEMI || c == CH_NUL) begin
            line_stopped = 1'b1;
         end else if (!((c >= CH_TAB && c <= CH_CR) || c == CH_SPACE)) begin
            if (digit[4]) begin
               line_key     = {line_key[KEY_W-5:0], digit[3:0]};
               line_nibbles = line_nibbles + 1'b1;
            end else begin
               line_bad     = 1'b1;
               line_stopped = 1'b1;
            end
         end
      end
   endtask

   // Insert into the store: a full store wins over a duplicate.
   task automatic file_key(input logic [KEY_W-1:0] k, output loader_result_type r);
      int  i;
      logic hit;
      hit         = 1'b0;
      r.status    = ST_ADDED;
      r.key_value = k;
      r.entry_slot = '0;
      if (held_total >= TABLE_DEPTH) begin
         r.status = ST_FULL;
      end else begin
         for (i = 0; i < held_total && !hit; i++) begin
            if (held_keys[i] == k) begin
               hit          = 1'b1;
               r.status     = ST_DUP;
               r.entry_slot = i[SLOT_W-1:0];
            end
         end
         if (!hit) begin
            held_keys[held_total] = k;
            r.entry_slot          = held_total[SLOT_W-1:0];
            held_total++;
         end
      end
      r.entry_count = held_total[CNT_W-1:0];
   endtask

   // Works out the result, if any, of one accepted request beat.
   task automatic predict_loader_beat();
      loader_result_type r;
      case (req_command)
         CMD_TEXT: begin
            parse_char(req_ch);
            if (req_last_in_line) begin
               if (line_bad || line_nibbles != KEY_NIBBLES) begin
                  r.status      = ST_BAD;
                  r.key_value   = '0;
                  r.entry_count = held_total[CNT_W-1:0];
                  r.entry_slot  = '0;
               end else begin
                  file_key(line_key, r);
               end
               line_nibbles = '0;
               line_key     = '0;
               line_stopped = 1'b0;
               line_bad     = 1'b0;
               awaited_results.push_back(r);
            end
         end
         CMD_INSERT: begin
            file_key(req_key, r);
            awaited_results.push_back(r);
         end
         CMD_READ: begin
            r.entry_count = held_total[CNT_W-1:0];
            r.entry_slot  = req_index;
            if (req_index < held_total) begin
               r.status    = ST_READ;
               r.key_value = held_keys[req_index];
            end else begin
               r.status    = ST_RANGE;
               r.key_value = '0;
            end
            awaited_results.push_back(r);
         end
         default: begin
            // The spare command code leaves everything as it was.
            r = '0;
         end
      endcase
   endtask

   // Compares one result beat with the oldest prediction.
   task automatic check_result();
      loader_result_type want;
      if (awaited_results.size() == 0) begin
         report_mismatch($sformatf("result with none awaited: status %0d key %h",
                                   rsp_status, rsp_key_value));
      end else begin
         want = awaited_results.pop_front();
         if (rsp_status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", rsp_status, want.status));
         if (rsp_key_value !== want.key_value)
            report_mismatch($sformatf("key_value %h, want %h",
                                      rsp_key_value, want.key_value));
         if (rsp_entry_count !== want.entry_count)
            report_mismatch($sformatf("entry_count %0d, want %0d",
                                      rsp_entry_count, want.entry_count));
         if (rsp_entry_slot !== want.entry_slot)
            report_mismatch($sformatf("entry_slot %0d, want %0d",
                                      rsp_entry_slot, want.entry_slot));
      end
   endtask

   // Results are checked before the request of the same edge is predicted,
   // so that a fresh prediction can never pair with an older result.
   always @(posedge clock) begin
      if (reset) begin
         held_total   = 0;
         line_nibbles = '0;
         line_key     = '0;
         line_stopped = 1'b0;
         line_bad     = 1'b0;
         fails        = 0;
         awaited_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            check_result();
         end
         if (req_valid && req_ready) begin
            predict_loader_beat();
         end
      end
      mismatch_count <= fails;
      awaited_count  <= awaited_results.size();
   end

endmodule

[bench/hex_key_line_dedup_loader_top_tb.sv]
module hex_key_line_dedup_loader_top_tb import hkl_pkg::*; ();

   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_SEMI  = 8'h3B;

   localparam int HOLD_CYCLES   = 150;
   localparam int DRAIN_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 600;
   localparam int RUN_LIMIT     = 1000000;

   logic              clock            = 1'b0;
   logic              reset            = 1'b1;
   logic              req_valid        = 1'b0;
   logic              req_ready;
   logic [1:0]        req_command      = CMD_TEXT;
   logic [7:0]        req_ch           = CH_SPACE;
   logic              req_last_in_line = 1'b0;
   logic [KEY_W-1:0]  req_key          = '0;
   logic [SLOT_W-1:0] req_index        = '0;
   logic              rsp_valid;
   logic              rsp_ready        = 1'b0;
   logic [2:0]        rsp_status;
   logic [KEY_W-1:0]  rsp_key_value;
   logic [CNT_W-1:0]  rsp_entry_count;
   logic [SLOT_W-1:0] rsp_entry_slot;

   int               mismatches;
   int               awaited;
   int               send_idle   = 0;
   int               recv_idle   = 0;
   int               hold_ticket = 0;
   int               hold_served = 0;
   int               hold_left   = 0;
   int               beats_sent  = 0;
   int               settle;
   logic [KEY_W-1:0] used_keys [$];
   logic [7:0]       line_buf [$];

   hex_key_line_dedup_loader_top uut (.*);

   hkl_result_checker checker_i (
      .*,
      .mismatch_count(mismatches),
      .awaited_count(awaited)
   );

   always #6 clock = ~clock;

   // Run limit, far beyond the slowest correct run.
   initial begin
      #(12 * RUN_LIMIT);
      $display("hex_key_line_dedup_loader_top_tb NOT OK");
      $finish;
   end

   // Result side: a long hold-off on request, random stalls otherwise.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_ticket) begin
         hold_served <= hold_ticket;
         hold_left   <= HOLD_CYCLES;
         rsp_ready   <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   function automatic logic [KEY_W-1:0] rand_key();
      logic [63:0] bits;
      bits = {$urandom, $urandom};
      return bits[KEY_W-1:0];
   endfunction

   // Mostly fresh keys, some repeats and a few corner patterns.
   function automatic logic [KEY_W-1:0] choose_key();
      logic [KEY_W-1:0] k;
      int               pick;
      pick = $urandom_range(99);
      if (pick < 25 && used_keys.size() != 0) begin
         k = used_keys[$urandom_range(used_keys.size() - 1)];
      end else begin
         if (pick < 28) k = '0;
         else if (pick < 31) k = '1;
         else if (pick < 36) k = {{(KEY_W-1){1'b0}}, 1'b1} << $urandom_range(KEY_W - 1);
         else k = rand_key();
         used_keys.push_back(k);
      end
      return k;
   endfunction

   // Indexes lean toward the low slots that are filled early on.
   function automatic logic [SLOT_W-1:0] pick_index();
      int pick;
      pick = $urandom_range(99);
      if (pick < 60) return SLOT_W'($urandom_range(15));
      else if (pick < 85) return SLOT_W'($urandom_range(63));
      return SLOT_W'($urandom_range(TABLE_DEPTH - 1));
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      string lower_digits;
      string upper_digits;
      lower_digits = "0123456789abcdef";
      upper_digits = "0123456789ABCDEF";
      if ($urandom_range(1) == 1) return upper_digits[n];
      return lower_digits[n];
   endfunction

   function automatic logic [7:0] space_char();
      if ($urandom_range(5) == 0) return CH_SPACE;
      return 8'(CH_TAB + $urandom_range(4));
   endfunction

   function automatic logic [7:0] stop_char();
      case ($urandom_range(2))
         0: return CH_HASH;
         1: return CH_SEMI;
         default: return CH_NUL;
      endcase
   endfunction

   // A character that is neither a digit, a blank nor a line stop.
   function automatic logic [7:0] bad_char();
      case ($urandom_range(5))
         0: return 8'("g" + $urandom_range(19));
         1: return 8'("G" + $urandom_range(19));
         2: return 8'(8'h80 + $urandom_range(127));
         3: return 8'(8'h01 + $urandom_range(7));
         4: return 8'(8'h0E + $urandom_range(17));
         default: return 8'("<" + $urandom_range(4));
      endcase
   endfunction

   // Drives one request beat and waits for it to be taken. Valid is
   // lowered only for a gap, never in the step that raises it again.
   task automatic send_beat(input logic [1:0] cmd, input logic [7:0] c, input logic last,
                            input logic [KEY_W-1:0] k, input logic [SLOT_W-1:0] idx);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_command      <= cmd;
      req_ch           <= c;
      req_last_in_line <= last;
      req_key          <= k;
      req_index        <= idx;
      do @(posedge clock); while (!req_ready);
      if (cmd != CMD_UNUSED) beats_sent++;
   endtask

   task automatic text_beat(input logic [7:0] c, input logic last);
      send_beat(CMD_TEXT, c, last, rand_key(), pick_index());
   endtask

   task automatic insert_beat(input logic [KEY_W-1:0] k);
      send_beat(CMD_INSERT, 8'($urandom), 1'($urandom), k, pick_index());
   endtask

   task automatic read_beat(input logic [SLOT_W-1:0] idx);
      send_beat(CMD_READ, 8'($urandom), 1'($urandom), rand_key(), idx);
   endtask

   task automatic send_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) begin
         text_beat(s[i], i == s.len() - 1);
      end
   endtask

   // Sends the buffered line; now and then a direct insert or a read
   // cuts in, which must leave the line parser alone.
   task automatic send_line();
      int i;
      for (i = 0; i < line_buf.size(); i++) begin
         if ($urandom_range(99) < 4) begin
            if ($urandom_range(1) == 1) insert_beat(choose_key());
            else read_beat(pick_index());
         end
         text_beat(line_buf[i], i == line_buf.size() - 1);
      end
   endtask

   // Twelve digits with blanks between, then one of several endings.
   task automatic build_good_line(input logic [KEY_W-1:0] k);
      int i;
      line_buf.delete();
      for (i = 11; i >= 0; i--) begin
         if ($urandom_range(99) < 15) line_buf.push_back(space_char());
         line_buf.push_back(hex_char(k[4*i +: 4]));
      end
      case ($urandom_range(4))
         0: begin
            // The last digit closes the line itself.
         end
         1: line_buf.push_back(CH_LF);
         2: begin
            line_buf.push_back(stop_char());
            repeat ($urandom_range(5)) line_buf.push_back(8'($urandom));
            line_buf.push_back(CH_LF);
         end
         3: begin
            // Anything past the twelfth digit is ignored.
            repeat ($urandom_range(1, 4)) begin
               if ($urandom_range(1) == 1) line_buf.push_back(hex_char(4'($urandom)));
               else line_buf.push_back(8'($urandom));
            end
            line_buf.push_back(CH_LF);
         end
         default: begin
            line_buf.push_back(space_char());
            line_buf.push_back(CH_LF);
         end
      endcase
   endtask

   // Fewer than twelve digits, cut short by a bad character, a stop or
   // just the line end.
   task automatic build_broken_line();
      int digits;
      int i;
      int kind;
      digits = $urandom_range(11);
      kind   = $urandom_range(2);
      line_buf.delete();
      for (i = 0; i < digits; i++) begin
         if ($urandom_range(9) == 0) line_buf.push_back(space_char());
         line_buf.push_back(hex_char(4'($urandom)));
      end
      if (kind != 2) begin
         line_buf.push_back(kind == 0 ? bad_char() : stop_char());
         repeat ($urandom_range(12)) line_buf.push_back(hex_char(4'($urandom)));
      end
      if (line_buf.size() == 0 || $urandom_range(1) == 1) line_buf.push_back(CH_LF);
   endtask

   task automatic build_noise_line();
      line_buf.delete();
      repeat ($urandom_range(1, 16)) line_buf.push_back(8'($urandom));
   endtask

   // Random traffic, mostly well-formed key lines.
   task automatic random_mix(input int beats);
      int stop_at;
      int pick;
      stop_at = beats_sent + beats;
      while (beats_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 45) begin
            build_good_line(choose_key());
            send_line();
         end else if (pick < 58) begin
            build_broken_line();
            send_line();
         end else if (pick < 63) begin
            build_noise_line();
            send_line();
         end else if (pick < 78) begin
            insert_beat(choose_key());
         end else if (pick < 93) begin
            read_beat(pick_index());
         end else begin
            send_beat(CMD_UNUSED, 8'($urandom), 1'($urandom), rand_key(), pick_index());
         end
      end
   endtask

   // Holds back new requests until every awaited result has come.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (awaited != 0);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty store, extremes, duplicates, odd lines.
      read_beat(9'd0);
      insert_beat('0);
      insert_beat('1);
      insert_beat('0);
      read_beat(9'd1);
      read_beat(9'd511);
      send_beat(CMD_UNUSED, CH_LF, 1'b1, '1, '1);
      send_text("\n");
      send_text("#");
      send_text("z");
      send_text("Ff09 aBcD\t12eE");
      read_beat(9'd2);
      used_keys.push_back(48'hFF09ABCD12EE);

      // Sender idles lightly, receiver heavily; starts with a long hold-off
      // while inserts keep coming, so the block backs up.
      send_idle = 13;
      recv_idle <= 48;
      hold_ticket <= hold_ticket + 1;
      repeat (8) insert_beat(choose_key());
      random_mix(130);
      wait_for_results();

      send_idle = 48;
      recv_idle <= 13;
      random_mix(130);
      wait_for_results();

      send_idle = 0;
      recv_idle <= 0;
      random_mix(130);

      // Close with a repeated key, a fresh line, reads and a broken line.
      insert_beat(used_keys[0]);
      build_good_line(rand_key());
      send_line();
      read_beat(9'd511);
      read_beat(9'd0);
      build_broken_line();
      send_line();
      req_valid <= 1'b0;

      settle = 0;
      while (awaited != 0 && settle < DRAIN_LIMIT) begin
         @(posedge clock);
         settle++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && awaited == 0) begin
         $display("hex_key_line_dedup_loader_top_tb OK");
      end else begin
         $display("hex_key_line_dedup_loader_top_tb NOT OK");
      end
      $finish;
   end

endmodule
